FILE: rtl/zdff_pkg.sv
`timescale 1ns / 1ps

package zdff_pkg;

    localparam int DEPTH     = 64;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int COUNT_W   = 7;
    localparam int MAX_RUN   = 64;
    localparam int RUN_W     = $clog2(MAX_RUN);

    localparam logic [COUNT_W-1:0] FRAMES_MAX = {COUNT_W{1'b1}};

    // commands
    localparam logic [1:0] CMD_PUSH      = 2'd0;
    localparam logic [1:0] CMD_POP_BYTE  = 2'd1;
    localparam logic [1:0] CMD_POP_FRAME = 2'd2;
    localparam logic [1:0] CMD_NOP       = 2'd3;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_DROP = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_in;
    } in_t;

    typedef struct packed {
        logic [7:0]         data_out;
        logic [1:0]         status;
        logic               last_of_run;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] frame_count;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic       push_en;
        logic       read_en;
        logic       pop_en;
        logic       load_out;
        logic [1:0] status;
        logic       last;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic zero_redundant;
        logic empty;
        logic no_frame;
        logic rd_is_zero;
        logic occ_one;
    } dp_sts_t;

endpackage

FILE: rtl/zdff_ram.sv
`timescale 1ns / 1ps

module zdff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/zdff_datapath.sv
`timescale 1ns / 1ps

module zdff_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [7:0]                     data_in,
    input  logic                           cfg_we,
    input  logic [zdff_pkg::COUNT_W-1:0]   cfg_data,
    input  zdff_pkg::dp_cmd_t              cmd,
    output zdff_pkg::dp_sts_t              sts,
    output zdff_pkg::out_t                 out_data
);

    import zdff_pkg::*;

    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] occ_reg, occ_next;
    logic [COUNT_W-1:0] frames_reg, frames_next;
    logic               lwz_reg, lwz_next;
    logic [COUNT_W-1:0] cap_reg, cap_next;
    out_t               out_reg, out_next;
    logic [7:0]         rd_data;

    // pointer wraps at the capacity in use
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [COUNT_W-1:0] cap);
        logic [COUNT_W-1:0] n;
        n = COUNT_W'(p) + COUNT_W'(1);
        if (n >= cap || n >= COUNT_W'(DEPTH))
            return '0;
        return n[PTR_W-1:0];
    endfunction

    zdff_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (data_in),
        .rd_en   (cmd.read_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        sts.full           = (occ_reg >= cap_reg);
        sts.zero_redundant = (data_in == 8'd0) && lwz_reg;
        sts.empty          = (occ_reg == '0);
        sts.no_frame       = (frames_reg == '0) || (occ_reg == '0);
        sts.rd_is_zero     = (rd_data == 8'd0);
        sts.occ_one        = (occ_reg == COUNT_W'(1));
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        frames_next = frames_reg;
        lwz_next    = lwz_reg;
        if (cmd.push_en)
        begin
            wr_ptr_next = advance(wr_ptr_reg, cap_reg);
            occ_next    = occ_reg + COUNT_W'(1);
            lwz_next    = (data_in == 8'd0);
            if (data_in == 8'd0 && frames_reg != FRAMES_MAX)
                frames_next = frames_reg + COUNT_W'(1);
        end
        else if (cmd.pop_en)
        begin
            rd_ptr_next = advance(rd_ptr_reg, cap_reg);
            occ_next    = occ_reg - COUNT_W'(1);
            if (rd_data == 8'd0 && frames_reg != '0)
                frames_next = frames_reg - COUNT_W'(1);
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.load_out)
        begin
            out_next.data_out    = cmd.pop_en ? rd_data : 8'd0;
            out_next.status      = cmd.status;
            out_next.last_of_run = cmd.last;
            out_next.used_count  = occ_next;
            out_next.frame_count = frames_next;
        end
    end

    // 0 acts as 1, anything above DEPTH as DEPTH
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_we)
        begin
            priority if (cfg_data == '0)
                cap_next = COUNT_W'(1);
            else if (cfg_data > COUNT_W'(DEPTH))
                cap_next = COUNT_W'(DEPTH);
            else
                cap_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
            frames_reg <= '0;
            lwz_reg    <= 1'b1;
            cap_reg    <= COUNT_W'(DEPTH);
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
            frames_reg <= frames_next;
            lwz_reg    <= lwz_next;
            cap_reg    <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule

FILE: rtl/zdff_ctrl.sv
`timescale 1ns / 1ps

module zdff_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_cmd,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  zdff_pkg::dp_sts_t sts,
    output zdff_pkg::dp_cmd_t cmd
);

    import zdff_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic             frame_reg, frame_next;
    logic             last_reg, last_next;
    logic [RUN_W-1:0] k_reg, k_next;
    logic             accept;
    logic             run_last;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_EMIT);

    // run ends on a byte pop, on a zero, on an empty buffer, or at the result limit
    assign run_last = !frame_reg || sts.rd_is_zero || sts.occ_one
                      || (k_reg == RUN_W'(MAX_RUN - 1));

    always_comb
    begin
        state_next = state_reg;
        frame_next = frame_reg;
        last_next  = last_reg;
        k_next     = k_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.last  = 1'b1;
                    last_next = 1'b1;
                    unique case (in_cmd)
                        CMD_PUSH:
                        begin
                            cmd.load_out = 1'b1;
                            state_next   = S_EMIT;
                            priority if (sts.full)
                                cmd.status = ST_FULL;
                            else if (sts.zero_redundant)
                                cmd.status = ST_ZERO_DROP;
                            else
                            begin
                                cmd.status  = ST_OK;
                                cmd.push_en = 1'b1;
                            end
                        end
                        CMD_POP_BYTE:
                        begin
                            if (sts.empty)
                            begin
                                cmd.load_out = 1'b1;
                                cmd.status   = ST_EMPTY;
                                state_next   = S_EMIT;
                            end
                            else
                            begin
                                cmd.read_en = 1'b1;
                                frame_next  = 1'b0;
                                state_next  = S_READ;
                            end
                        end
                        CMD_POP_FRAME:
                        begin
                            if (sts.no_frame)
                            begin
                                cmd.load_out = 1'b1;
                                cmd.status   = ST_EMPTY;
                                state_next   = S_EMIT;
                            end
                            else
                            begin
                                cmd.read_en = 1'b1;
                                frame_next  = 1'b1;
                                k_next      = '0;
                                state_next  = S_READ;
                            end
                        end
                        CMD_NOP:
                        begin
                            cmd.load_out = 1'b1;
                            cmd.status   = ST_OK;
                            state_next   = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.pop_en   = 1'b1;
                cmd.load_out = 1'b1;
                cmd.status   = ST_OK;
                cmd.last     = run_last;
                last_next    = run_last;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    if (last_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.read_en = 1'b1;
                        k_next      = k_reg + RUN_W'(1);
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            frame_reg <= 1'b0;
            last_reg  <= 1'b1;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            frame_reg <= frame_next;
            last_reg  <= last_next;
            k_reg     <= k_next;
        end
    end

endmodule

FILE: rtl/zero_delimited_frame_fifo_core.sv
`timescale 1ns / 1ps

// Byte FIFO for zero-delimited frames, 64 bytes of storage.
// Input channel (in_valid / in_stall / in_data): one beat is a command
//   (push byte, pop byte, pop whole frame) plus the byte to push.
// Output channel (out_valid / out_stall / out_data): one beat per result,
//   carrying the popped byte, status, end-of-run flag, and the occupancy
//   and frame count after that result. A frame pop gives one beat per byte.
// Config channel (cfg_valid / cfg_ready / cfg_data): capacity in bytes,
//   always ready; write only while no command is in flight.
// Timing: one command at a time. A push, a failed pop or an unused command
//   shows its result the cycle after acceptance. Each popped byte costs a
//   storage read plus the output register; a frame pop streams its bytes
//   in turn, reading the next byte only once the previous beat leaves. The
//   next command is taken in the cycle after the final beat leaves.
// While out_stall is high the result beat is held and the engine waits.
// Reset clears pointers, counts and the capacity (back to 64); storage
//   contents are not cleared and need no clearing pass.
module zero_delimited_frame_fifo_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  zdff_pkg::in_t                in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output zdff_pkg::out_t               out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [zdff_pkg::COUNT_W-1:0] cfg_data
);

    import zdff_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    assign cfg_ready = 1'b1;

    zdff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    zdff_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .data_in  (in_data.data_in),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (dp_cmd),
        .sts      (dp_sts),
        .out_data (out_data)
    );

endmodule

FILE: tb/zdff_result_checker.sv
`timescale 1ns / 1ps

module zdff_result_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  zdff_pkg::in_t                in_data,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  zdff_pkg::out_t               out_data,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [zdff_pkg::COUNT_W-1:0] cfg_data,
    output int                           mismatch_count,
    output int                           beats_pending,
    output int                           fifo_level
);
    import zdff_pkg::*;

    logic [7:0]         ring_bytes [DEPTH];
    logic [PTR_W-1:0]   wr_ptr;
    logic [PTR_W-1:0]   rd_ptr;
    logic [COUNT_W-1:0] bytes_held;
    logic [COUNT_W-1:0] frames_held;
    logic [COUNT_W-1:0] cap_in_use;
    logic               last_byte_zero;
    out_t               expected_beats [$];
    int                 errors = 0;

    assign mismatch_count = errors;

    // pointers wrap at the capacity in use, never beyond the storage
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        int n;
        n = int'(p) + 1;
        if (n >= int'(cap_in_use) || n >= DEPTH)
            return '0;
        return n[PTR_W-1:0];
    endfunction

    task automatic add_expected(input logic [7:0] d, input logic [1:0] st,
                                input logic last);
        out_t b;
        b.data_out    = d;
        b.status      = st;
        b.last_of_run = last;
        b.used_count  = bytes_held;
        b.frame_count = frames_held;
        expected_beats.push_back(b);
    endtask

    task automatic take_oldest(output logic [7:0] d);
        d = ring_bytes[rd_ptr];
        rd_ptr = next_ptr(rd_ptr);
        bytes_held = bytes_held - COUNT_W'(1);
        if (d == 8'd0 && frames_held != '0)
            frames_held = frames_held - COUNT_W'(1);
    endtask

    task automatic predict_command(input in_t c);
        logic [7:0] d;
        int         k;
        bit         stop;
        case (c.cmd)
            CMD_PUSH: begin
                if (bytes_held >= cap_in_use)
                    add_expected(8'd0, ST_FULL, 1'b1);
                else if (c.data_in == 8'd0 && last_byte_zero)
                    add_expected(8'd0, ST_ZERO_DROP, 1'b1);
                else
                begin
                    if (c.data_in == 8'd0 && frames_held < FRAMES_MAX)
                        frames_held = frames_held + COUNT_W'(1);
                    ring_bytes[wr_ptr] = c.data_in;
                    wr_ptr = next_ptr(wr_ptr);
                    last_byte_zero = (c.data_in == 8'd0);
                    bytes_held = bytes_held + COUNT_W'(1);
                    add_expected(8'd0, ST_OK, 1'b1);
                end
            end
            CMD_POP_BYTE: begin
                if (bytes_held == '0)
                    add_expected(8'd0, ST_EMPTY, 1'b1);
                else
                begin
                    take_oldest(d);
                    add_expected(d, ST_OK, 1'b1);
                end
            end
            CMD_POP_FRAME: begin
                if (frames_held == '0 || bytes_held == '0)
                    add_expected(8'd0, ST_EMPTY, 1'b1);
                else
                begin
                    k = 0;
                    stop = 1'b0;
                    while (!stop)
                    begin
                        take_oldest(d);
                        k++;
                        stop = (d == 8'd0) || (bytes_held == '0) || (k >= MAX_RUN);
                        add_expected(d, ST_OK, stop);
                    end
                end
            end
            default: add_expected(8'd0, ST_OK, 1'b1);
        endcase
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endtask

    task automatic check_beat(input out_t got);
        out_t want;
        if (expected_beats.size() == 0)
        begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = expected_beats.pop_front();
        compare_field("data_out", want.data_out, got.data_out);
        compare_field("status", 8'(want.status), 8'(got.status));
        compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
        compare_field("used_count", 8'(want.used_count), 8'(got.used_count));
        compare_field("frame_count", 8'(want.frame_count), 8'(got.frame_count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr         = '0;
            rd_ptr         = '0;
            bytes_held     = '0;
            frames_held    = '0;
            last_byte_zero = 1'b1;
            cap_in_use     = COUNT_W'(DEPTH);
            expected_beats.delete();
            beats_pending <= 0;
            fifo_level    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data == '0)
                    cap_in_use = COUNT_W'(1);
                else if (int'(cfg_data) > DEPTH)
                    cap_in_use = COUNT_W'(DEPTH);
                else
                    cap_in_use = cfg_data;
            end
            if (in_valid && !in_stall)
                predict_command(in_data);
            if (out_valid && !out_stall)
                check_beat(out_data);
            beats_pending <= expected_beats.size();
            fifo_level    <= int'(bytes_held);
        end
    end

endmodule

FILE: tb/tb_zero_delimited_frame_fifo_core.sv
`timescale 1ns / 1ps

module tb_zero_delimited_frame_fifo_core;
    import zdff_pkg::*;

    // minimum number of command beats to send in all and the one long receiver hold-off
    localparam int RANDOM_ITEMS = 160;
    localparam int HOLD_CYCLES  = 80;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_t                in_data;
    logic               out_valid;
    logic               out_stall;
    out_t               out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    int mismatch_count;
    int beats_pending;
    int fifo_level;
    int items_sent;

    // no_idle: both sides run without gaps for the current phase
    bit no_idle;
    // long_hold_armed: the result side takes one long hold-off at its next beat
    bit long_hold_armed;

    always #5 clk = ~clk;

    zero_delimited_frame_fifo_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // watches all three channels, predicts every result beat and compares
    zdff_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending),
        .fifo_level     (fifo_level)
    );

    // One command beat. The gap before it is drawn independently of stall;
    // valid stays high after acceptance so back-to-back beats need no toggle.
    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] data);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {cmd, data};
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // len - 1 nonzero bytes followed by the delimiting zero
    task automatic push_frame(input int len);
        repeat (len - 1) send_cmd(CMD_PUSH, 8'($urandom_range(1, 255)));
        send_cmd(CMD_PUSH, 8'h00);
    endtask

    // Drop valid and wait until every predicted beat has come back. Every
    // command yields a beat, so after that only the hand-back to idle is left.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (beats_pending != 0);
        repeat (3) @(posedge clk);
    endtask

    // only called with no command in flight
    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Empty the FIFO with byte pops. In the random part capacity only changes
    // on an empty FIFO (read and write pointers then coincide), so no read can
    // ever land on a storage entry that was never written.
    task automatic drain_fifo();
        int n;
        wait_idle();
        n = fifo_level;
        repeat (n) send_cmd(CMD_POP_BYTE, 8'($urandom));
        wait_idle();
    endtask

    // Result side: per beat a random hold-off, none in no_idle phases, raised
    // before the beat shows so stalls land on every phase of the engine. Once,
    // a long hold-off counted here while the sender keeps offering commands.
    initial
    begin : result_stall_driver
        int hold_off;
        bit hold_done;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                hold_off  = HOLD_CYCLES;
            end
            else
                hold_off = no_idle ? 0 : $urandom_range(0, 10);
            if (hold_off > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : run_limit
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int len;
        int pick;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        no_idle         = 1'b0;
        long_hold_armed = 1'b0;
        items_sent      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // empty FIFO: byte pop answers empty, frame pop answers no frame
        send_cmd(CMD_POP_BYTE, 8'hFF);
        send_cmd(CMD_POP_FRAME, 8'h00);
        // zero before any stored byte is dropped
        send_cmd(CMD_PUSH, 8'h00);
        // unused command: a single ok beat, nothing changes
        send_cmd(CMD_NOP, 8'hFF);
        // one frame, then a redundant zero right after its delimiter
        send_cmd(CMD_PUSH, 8'hFF);
        send_cmd(CMD_PUSH, 8'h01);
        send_cmd(CMD_PUSH, 8'h00);
        send_cmd(CMD_PUSH, 8'h00);
        // frame pop streams three beats, last one flagged
        send_cmd(CMD_POP_FRAME, 8'hFF);
        // byte pops across a delimiter: frame count drops on the zero
        send_cmd(CMD_PUSH, 8'h80);
        send_cmd(CMD_PUSH, 8'h00);
        send_cmd(CMD_POP_BYTE, 8'h00);
        send_cmd(CMD_POP_BYTE, 8'h00);
        wait_idle();

        // small capacity, then raised with data stored (pointers not wrapped)
        write_capacity(COUNT_W'(16));
        send_cmd(CMD_PUSH, 8'h55);
        send_cmd(CMD_PUSH, 8'hAA);
        send_cmd(CMD_PUSH, 8'h00);
        send_cmd(CMD_PUSH, 8'h7F);
        wait_idle();
        write_capacity(COUNT_W'(DEPTH));
        send_cmd(CMD_POP_FRAME, 8'h00);
        send_cmd(CMD_POP_BYTE, 8'h00);
        wait_idle();

        // capacity 0 acts as one byte: second push is full
        write_capacity('0);
        send_cmd(CMD_PUSH, 8'h3C);
        send_cmd(CMD_PUSH, 8'hC3);
        send_cmd(CMD_POP_BYTE, 8'h00);
        send_cmd(CMD_POP_BYTE, 8'h00);
        wait_idle();

        // all ones is above the depth and clamps to it
        write_capacity('1);

        // ---- random part ----
        // Each phase starts empty with a fresh capacity and idling mode.
        // Mostly well-formed frames with random content, mixed with pops,
        // stray zeros, random bytes and raw commands. The largest-frame and
        // long hold-off phases always run.
        phase = 0;
        while (items_sent < RANDOM_ITEMS || phase <= 2)
        begin
            drain_fifo();
            no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 1)
            begin
                // largest frame: fills all storage, then full, then 64 beats
                write_capacity(COUNT_W'(DEPTH));
                push_frame(DEPTH);
                send_cmd(CMD_PUSH, 8'hA5);
                send_cmd(CMD_POP_FRAME, 8'h00);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       write_capacity(COUNT_W'(DEPTH));
                    1:       write_capacity('1);
                    2:       write_capacity(COUNT_W'($urandom_range(0, 1)));
                    3:       write_capacity(COUNT_W'($urandom_range(2, 8)));
                    default: write_capacity(COUNT_W'($urandom_range(1, 127)));
                endcase
                if (phase == 2)
                begin
                    // receiver holds off long while commands keep coming
                    no_idle = 1'b1;
                    long_hold_armed = 1'b1;
                end
                repeat ($urandom_range(8, 20))
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40)
                    begin
                        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                          : $urandom_range(1, 6);
                        push_frame(len);
                    end
                    else if (pick < 62)
                        send_cmd(CMD_POP_FRAME, 8'($urandom));
                    else if (pick < 80)
                        send_cmd(CMD_POP_BYTE, 8'($urandom));
                    else if (pick < 92)
                        send_cmd(CMD_PUSH, $urandom_range(0, 1) ? 8'h00 : 8'($urandom));
                    else
                        send_cmd(2'($urandom), 8'($urandom));
                end
            end
            phase++;
        end

        // ---- wrap-up ----
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
